[rtl/pip_pkg.sv]
`default_nettype none

package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VCNT_W       = 7;
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_END_X    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } pip_state_t;

  typedef enum logic [1:0] {
    ORI_COL,
    ORI_CW,
    ORI_CCW
  } orient_t;

  function automatic orient_t ori_code(input logic signed [PROD_W-1:0] p,
                                       input logic signed [PROD_W-1:0] q);
    orient_t o;
    if (p == q) begin
      o = ORI_COL;
    end else if (p > q) begin
      o = ORI_CW;
    end else begin
      o = ORI_CCW;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[rtl/point_in_polygon_test_core.sv]
`default_nettype none

// Point-in-polygon test by horizontal ray crossing.
// Input channel (in_valid/in_ready): a transaction with in_command = write
// stores (in_coord_x, in_coord_y) into vertex slot in_vertex_index and gives
// no result; a transaction with in_command = test gives one result on the
// output channel (out_valid/out_ready): out_inside_res is 1 for a point inside
// the polygon or on its boundary.
// Config port: cfg_wr_en writes cfg_data into register cfg_index
// (0: vertex_count, 1: ray_end_x); write only while the core is idle.
// Vertex writes are accepted back to back. A test with n = min(vertex_count, 64)
// vertices reads the vertex memory once per cycle (n + 1 reads, the first
// vertex again to close the polygon) into a four-stage edge pipeline; the
// single read port of the vertex memory sets this rate. The core takes no
// new transaction until the result is loaded into the output register; with
// fewer than three vertices the walk is skipped and the result is outside.
// A result waits in the output register while out_ready is low; the core
// still accepts vertex writes and a new test, and a finished test holds
// until the output register is free.
// Reset clears control state and sets vertex_count to 0 and ray_end_x to the
// largest positive value; vertex memory contents stay undefined until written.

module point_in_polygon_test_core
  import pip_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_command,
  input  wire logic [VIDX_W-1:0]           in_vertex_index,
  input  wire logic signed [COORD_W-1:0]   in_coord_x,
  input  wire logic signed [COORD_W-1:0]   in_coord_y,

  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_inside_res,

  input  wire logic                        cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  pip_state_t state_r, state_nxt;

  logic [VCNT_W-1:0]          vcount_r;
  logic signed [COORD_W-1:0]  ray_x_r;
  logic signed [COORD_W-1:0]  pt_x_r, pt_y_r;
  logic [CNT_W-1:0]           n_eff;
  logic [CNT_W-1:0]           rd_cnt_r;
  logic [VIDX_W-1:0]          rd_addr;
  logic                       rd_en, rd_last;
  logic                       in_acc, wr_acc, test_acc, short_poly;
  logic                       load_out;

  logic [COORD_W-1:0]         vertex_x_store [MAX_VERTICES];
  logic [COORD_W-1:0]         vertex_y_store [MAX_VERTICES];
  logic signed [COORD_W-1:0]  bx_q_r, by_q_r, ax_r, ay_r;
  logic                       rd_vld_r, rd_first_r, rd_last_r;

  logic signed [DIFF_W-1:0]   d_byay, d_pxbx, d_bxax, d_pyby, d_rxbx;
  logic signed [DIFF_W-1:0]   d_pyay, d_bxpx, d_pxax, d_bypy;
  logic signed [DIFF_W-1:0]   s1_byay_r, s1_pxbx_r, s1_bxax_r, s1_pyby_r, s1_rxbx_r;
  logic signed [DIFF_W-1:0]   s1_pyay_r, s1_bxpx_r, s1_pxax_r, s1_bypy_r;
  orient_t                    o3, o4, s1_o3_r, s1_o4_r, s2_o3_r, s2_o4_r;
  logic                       pin, din, ain, bin;
  logic                       s1_pin_r, s1_din_r, s1_ain_r, s1_bin_r, s1_vld_r, s1_last_r;

  logic signed [PROD_W-1:0]   s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r, s2_p5_r;
  logic                       s2_pin_r, s2_din_r, s2_ain_r, s2_bin_r, s2_vld_r, s2_last_r;

  orient_t                    o1, o2, oc;
  logic                       meet;
  logic                       s3_meet_r, s3_col_r, s3_pin_r, s3_vld_r, s3_last_r;

  logic                       decided_r, ans_r, parity_r;
  logic                       out_valid_r, out_res_r;

  assign in_acc     = in_valid && in_ready;
  assign wr_acc     = in_acc && (in_command == CMD_WRITE);
  assign test_acc   = in_acc && (in_command == CMD_TEST);
  assign n_eff      = (32'(vcount_r) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                          : CNT_W'(vcount_r);
  assign short_poly = (n_eff < CNT_W'(3));
  assign rd_last    = (rd_cnt_r == n_eff);
  assign rd_addr    = rd_last ? '0 : rd_cnt_r[VIDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (test_acc) begin
          state_nxt = short_poly ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s3_vld_r && s3_last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_WALK:  rd_en    = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  load_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vcount_r <= '0;
      ray_x_r  <= {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_VERTEX_COUNT: vcount_r <= cfg_data[VCNT_W-1:0];
          REG_RAY_END_X:    ray_x_r  <= $signed(cfg_data[COORD_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (test_acc) begin
      pt_x_r <= in_coord_x;
      pt_y_r <= in_coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
    end else if (test_acc) begin
      rd_cnt_r <= '0;
    end else if (rd_en) begin
      rd_cnt_r <= rd_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_acc) begin
      vertex_x_store[in_vertex_index] <= in_coord_x;
      vertex_y_store[in_vertex_index] <= in_coord_y;
    end
    if (rd_en) begin
      bx_q_r <= $signed(vertex_x_store[rd_addr]);
      by_q_r <= $signed(vertex_y_store[rd_addr]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= (rd_cnt_r == '0);
    rd_last_r  <= rd_last;
    if (rd_vld_r) begin
      ax_r <= bx_q_r;
      ay_r <= by_q_r;
    end
  end

  // edge A = previous vertex, B = vertex just read; ray from P to (ray_x, py)
  assign d_byay = DIFF_W'(by_q_r) - DIFF_W'(ay_r);
  assign d_pxbx = DIFF_W'(pt_x_r) - DIFF_W'(bx_q_r);
  assign d_bxax = DIFF_W'(bx_q_r) - DIFF_W'(ax_r);
  assign d_pyby = DIFF_W'(pt_y_r) - DIFF_W'(by_q_r);
  assign d_rxbx = DIFF_W'(ray_x_r) - DIFF_W'(bx_q_r);
  assign d_pyay = DIFF_W'(pt_y_r) - DIFF_W'(ay_r);
  assign d_bxpx = DIFF_W'(bx_q_r) - DIFF_W'(pt_x_r);
  assign d_pxax = DIFF_W'(pt_x_r) - DIFF_W'(ax_r);
  assign d_bypy = DIFF_W'(by_q_r) - DIFF_W'(pt_y_r);

  always_comb begin
    if ((ray_x_r == pt_x_r) || (ay_r == pt_y_r)) begin
      o3 = ORI_COL;
    end else if ((ray_x_r > pt_x_r) != (ay_r > pt_y_r)) begin
      o3 = ORI_CW;
    end else begin
      o3 = ORI_CCW;
    end
    if ((ray_x_r == pt_x_r) || (by_q_r == pt_y_r)) begin
      o4 = ORI_COL;
    end else if ((ray_x_r > pt_x_r) != (by_q_r > pt_y_r)) begin
      o4 = ORI_CW;
    end else begin
      o4 = ORI_CCW;
    end
  end

  assign pin = (pt_x_r <= ax_r || pt_x_r <= bx_q_r) && (pt_x_r >= ax_r || pt_x_r >= bx_q_r) &&
               (pt_y_r <= ay_r || pt_y_r <= by_q_r) && (pt_y_r >= ay_r || pt_y_r >= by_q_r);
  assign din = (ray_x_r <= ax_r || ray_x_r <= bx_q_r) &&
               (ray_x_r >= ax_r || ray_x_r >= bx_q_r) &&
               (pt_y_r <= ay_r || pt_y_r <= by_q_r) && (pt_y_r >= ay_r || pt_y_r >= by_q_r);
  assign ain = (ax_r <= pt_x_r || ax_r <= ray_x_r) && (ax_r >= pt_x_r || ax_r >= ray_x_r) &&
               (ay_r == pt_y_r);
  assign bin = (bx_q_r <= pt_x_r || bx_q_r <= ray_x_r) &&
               (bx_q_r >= pt_x_r || bx_q_r >= ray_x_r) && (by_q_r == pt_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= rd_vld_r && !rd_first_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_byay_r <= d_byay;
    s1_pxbx_r <= d_pxbx;
    s1_bxax_r <= d_bxax;
    s1_pyby_r <= d_pyby;
    s1_rxbx_r <= d_rxbx;
    s1_pyay_r <= d_pyay;
    s1_bxpx_r <= d_bxpx;
    s1_pxax_r <= d_pxax;
    s1_bypy_r <= d_bypy;
    s1_o3_r   <= o3;
    s1_o4_r   <= o4;
    s1_pin_r  <= pin;
    s1_din_r  <= din;
    s1_ain_r  <= ain;
    s1_bin_r  <= bin;
    s1_last_r <= rd_last_r;
  end

  always_ff @(posedge clk) begin
    s2_p1_r   <= PROD_W'(s1_byay_r) * PROD_W'(s1_pxbx_r);
    s2_p2_r   <= PROD_W'(s1_bxax_r) * PROD_W'(s1_pyby_r);
    s2_p3_r   <= PROD_W'(s1_byay_r) * PROD_W'(s1_rxbx_r);
    s2_p4_r   <= PROD_W'(s1_pyay_r) * PROD_W'(s1_bxpx_r);
    s2_p5_r   <= PROD_W'(s1_pxax_r) * PROD_W'(s1_bypy_r);
    s2_o3_r   <= s1_o3_r;
    s2_o4_r   <= s1_o4_r;
    s2_pin_r  <= s1_pin_r;
    s2_din_r  <= s1_din_r;
    s2_ain_r  <= s1_ain_r;
    s2_bin_r  <= s1_bin_r;
    s2_last_r <= s1_last_r;
  end

  assign o1   = ori_code(s2_p1_r, s2_p2_r);
  assign o2   = ori_code(s2_p3_r, s2_p2_r);
  assign oc   = ori_code(s2_p4_r, s2_p5_r);
  assign meet = ((o1 != o2) && (s2_o3_r != s2_o4_r)) ||
                ((o1 == ORI_COL) && s2_pin_r) || ((o2 == ORI_COL) && s2_din_r) ||
                ((s2_o3_r == ORI_COL) && s2_ain_r) || ((s2_o4_r == ORI_COL) && s2_bin_r);

  always_ff @(posedge clk) begin
    s3_meet_r <= meet;
    s3_col_r  <= (oc == ORI_COL);
    s3_pin_r  <= s2_pin_r;
    s3_last_r <= s2_last_r;
  end

  // first collinear edge met decides; otherwise count crossings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decided_r <= 1'b0;
      ans_r     <= 1'b0;
      parity_r  <= 1'b0;
    end else if (test_acc) begin
      decided_r <= short_poly;
      ans_r     <= 1'b0;
      parity_r  <= 1'b0;
    end else if (s3_vld_r && !decided_r && s3_meet_r) begin
      if (s3_col_r) begin
        decided_r <= 1'b1;
        ans_r     <= s3_pin_r;
      end else begin
        parity_r <= !parity_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= decided_r ? ans_r : parity_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r;

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(rd_vld_r || s1_vld_r || s2_vld_r || s3_vld_r))
    else $error("edge pipeline busy while accepting");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (rd_cnt_r <= n_eff))
    else $error("read counter past vertex count");

  a_short_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (test_acc && short_poly) |=> ((state_r == ST_DONE) && decided_r && !ans_r))
    else $error("short polygon not answered outside");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result not presented");
`endif

endmodule

`default_nettype wire

[test/tb_pip_inside_checker.sv]
`timescale 1ns / 1ps

module tb_pip_inside_checker
  import pip_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic                      in_command,
  input  wire logic [VIDX_W-1:0]         in_vertex_index,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic                      out_inside_res,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data,
  output int                             mismatch_count,
  output int                             open_tests
);

  localparam int DUE_DEPTH = 4;

  logic signed [COORD_W-1:0] vx_store [MAX_VERTICES];
  logic signed [COORD_W-1:0] vy_store [MAX_VERTICES];
  logic [VCNT_W-1:0]         vertex_total;
  logic signed [COORD_W-1:0] ray_end;
  bit                        due_ring [DUE_DEPTH];
  int                        due_rd;
  int                        due_wr;
  int                        due_cnt;
  bit                        due;

  function automatic logic signed [PROD_W-1:0] wide(input logic signed [COORD_W-1:0] v);
    return v;
  endfunction

  // turn direction of p -> q -> r, exact over the full coordinate range
  function automatic orient_t turn_of(input logic signed [COORD_W-1:0] px, py, qx, qy, rx, ry);
    logic signed [PROD_W-1:0] lhs;
    logic signed [PROD_W-1:0] rhs;
    lhs = (wide(qy) - wide(py)) * (wide(rx) - wide(qx));
    rhs = (wide(qx) - wide(px)) * (wide(ry) - wide(qy));
    if (lhs == rhs) begin
      return ORI_COL;
    end else if (lhs > rhs) begin
      return ORI_CW;
    end
    return ORI_CCW;
  endfunction

  // q within the bounding box of p and r
  function automatic bit in_box(input logic signed [COORD_W-1:0] px, py, qx, qy, rx, ry);
    logic signed [COORD_W-1:0] xlo, xhi, ylo, yhi;
    xhi = (px > rx) ? px : rx;
    xlo = (px < rx) ? px : rx;
    yhi = (py > ry) ? py : ry;
    ylo = (py < ry) ? py : ry;
    return (qx <= xhi) && (qx >= xlo) && (qy <= yhi) && (qy >= ylo);
  endfunction

  function automatic bit ray_meets_edge(input logic signed [COORD_W-1:0] ax, ay, bx, by,
                                        input logic signed [COORD_W-1:0] cx, cy, dx, dy);
    orient_t o1, o2, o3, o4;
    o1 = turn_of(ax, ay, bx, by, cx, cy);
    o2 = turn_of(ax, ay, bx, by, dx, dy);
    o3 = turn_of(cx, cy, dx, dy, ax, ay);
    o4 = turn_of(cx, cy, dx, dy, bx, by);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == ORI_COL && in_box(ax, ay, cx, cy, bx, by)) return 1'b1;
    if (o2 == ORI_COL && in_box(ax, ay, dx, dy, bx, by)) return 1'b1;
    if (o3 == ORI_COL && in_box(cx, cy, ax, ay, dx, dy)) return 1'b1;
    if (o4 == ORI_COL && in_box(cx, cy, bx, by, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit point_inside(input logic signed [COORD_W-1:0] px, py);
    int n, i, j, crossings;
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    n = (vertex_total > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_total);
    if (n < 3) return 1'b0;
    crossings = 0;
    for (i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      ax = vx_store[i];
      ay = vy_store[i];
      bx = vx_store[j];
      by = vy_store[j];
      if (ray_meets_edge(ax, ay, bx, by, px, py, ray_end, py)) begin
        // boundary hit decides at once
        if (turn_of(ax, ay, px, py, bx, by) == ORI_COL) return in_box(ax, ay, px, py, bx, by);
        crossings++;
      end
    end
    return crossings[0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      vertex_total = '0;
      ray_end = 32'sh7FFF_FFFF;
      due_rd = 0;
      due_wr = 0;
      due_cnt = 0;
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_VERTEX_COUNT: vertex_total = cfg_data[VCNT_W-1:0];
          REG_RAY_END_X:    ray_end = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_cnt == 0) begin
          $error("out_inside_res: expected none, actual %0b", out_inside_res);
          mismatch_count++;
        end else begin
          due = due_ring[due_rd];
          due_rd = (due_rd + 1) % DUE_DEPTH;
          due_cnt--;
          if (due !== out_inside_res) begin
            $error("out_inside_res: expected %0b, actual %0b", due, out_inside_res);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_command == CMD_WRITE) begin
          vx_store[in_vertex_index] = in_coord_x;
          vy_store[in_vertex_index] = in_coord_y;
        end else if (due_cnt == DUE_DEPTH) begin
          $error("out_inside_res: expected at most %0d open tests, actual %0d",
                 DUE_DEPTH, due_cnt + 1);
          mismatch_count++;
        end else begin
          due_ring[due_wr] = point_inside(in_coord_x, in_coord_y);
          due_wr = (due_wr + 1) % DUE_DEPTH;
          due_cnt++;
        end
      end
    end
    open_tests = due_cnt;
  end

endmodule

[test/tb_point_in_polygon_test_core.sv]
`timescale 1ns / 1ps

module tb_point_in_polygon_test_core;
  import pip_pkg::*;

  localparam int ITEM_GOAL = 1700;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE    = 80;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] UNIT  = 32'sh0001_0000;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_command;
  logic [VIDX_W-1:0]         in_vertex_index;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_inside_res;
  logic                      cfg_wr_en;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  int                        mismatch_count;
  int                        open_tests;

  int                        items_sent;
  int                        send_gap_pct;
  bit                        no_idle;
  bit                        long_hold_req;
  int                        frame_sh;
  int                        frame_offx;
  int                        frame_offy;
  int                        poly_n;
  logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];

  point_in_polygon_test_core i_dut (.*);

  tb_pip_inside_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #15_000_000;
    $display("tb_point_in_polygon_test_core: errors");
    $finish;
  end

  // result side: random stall bursts, calm stretches, one long hold-off
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (no_idle || calm_left > 0) begin
        if (calm_left > 0) calm_left--;
        out_ready <= 1'b1;
      end else if ($urandom_range(9) == 0) begin
        stall_left = $urandom_range(14);
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(99) == 0) calm_left = $urandom_range(200, 50);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic signed [COORD_W-1:0] grid_pt(input int g, input int off);
    return COORD_W'(longint'(g) * (longint'(1) << frame_sh) + longint'(off));
  endfunction

  // walk the perimeter of a 16 x 16 square, counterclockwise
  function automatic void ring_xy(input int t, output int gx, output int gy);
    int u;
    u = (t % 16) - 8;
    case (t / 16)
      0:       begin gx = u;  gy = -8; end
      1:       begin gx = 8;  gy = u;  end
      2:       begin gx = -u; gy = 8;  end
      default: begin gx = -8; gy = -u; end
    endcase
  endfunction

  task automatic send_item(input logic cmd, input int idx,
                           input logic signed [COORD_W-1:0] x, y);
    int gap;
    if (!no_idle && pick(0, 99) < send_gap_pct) begin
      gap = pick(0, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_vertex_index <= VIDX_W'(idx);
    in_coord_x      <= x;
    in_coord_y      <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_vertex(input int idx, input logic signed [COORD_W-1:0] x, y);
    send_item(CMD_WRITE, idx, x, y);
  endtask

  task automatic probe_point(input logic signed [COORD_W-1:0] x, y);
    send_item(CMD_TEST, pick(0, MAX_VERTICES - 1), x, y);
  endtask

  // drop valid, wait for every open test, then let the core go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (open_tests != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(input int cnt, input logic signed [COORD_W-1:0] ray, input bit junk);
    logic [CFG_DATA_W-1:0] cnt_word;
    cnt_word = CFG_DATA_W'(cnt);
    if (junk) cnt_word = cnt_word | ($urandom() & 32'hFFFF_FF80);
    if (pick(0, 1) == 1) begin
      set_reg(REG_VERTEX_COUNT, cnt_word);
      set_reg(REG_RAY_END_X, ray);
    end else begin
      set_reg(REG_RAY_END_X, ray);
      set_reg(REG_VERTEX_COUNT, cnt_word);
    end
  endtask

  task automatic build_polygon(input int n);
    int k, gx, gy;
    bit ring, mirror;
    ring = (pick(0, 2) != 0);
    mirror = pick(0, 1);
    poly_n = n;
    for (k = 0; k < n; k++) begin
      if (ring) begin
        ring_xy((k * 64) / n, gx, gy);
      end else begin
        gx = pick(-6, 6);
        gy = pick(-6, 6);
      end
      if (mirror) gx = -gx;
      poly_x[k] = grid_pt(gx, frame_offx);
      poly_y[k] = grid_pt(gy, frame_offy);
      if (n < MAX_VERTICES && pick(0, 99) < 8) begin
        put_vertex(pick(n, MAX_VERTICES - 1), $urandom(), $urandom());
      end
      put_vertex(k, poly_x[k], poly_y[k]);
    end
    // break the shape now and then
    if (n > 0 && pick(0, 99) < 5) begin
      put_vertex(pick(0, n - 1), grid_pt(pick(-6, 6), frame_offx),
                 grid_pt(pick(-6, 6), frame_offy));
    end
  endtask

  task automatic pick_point(output logic signed [COORD_W-1:0] x, y);
    int r, k, j;
    r = pick(0, 99);
    k = (poly_n > 0) ? pick(0, poly_n - 1) : 0;
    j = (k + 1 >= poly_n) ? 0 : k + 1;
    if (poly_n == 0 || r < 45) begin
      x = grid_pt(pick(-10, 10), frame_offx);
      y = grid_pt(pick(-10, 10), frame_offy);
    end else if (r < 60) begin
      x = poly_x[k];
      y = poly_y[k];
    end else if (r < 72) begin
      x = COORD_W'((longint'(poly_x[k]) + longint'(poly_x[j])) >>> 1);
      y = COORD_W'((longint'(poly_y[k]) + longint'(poly_y[j])) >>> 1);
    end else if (r < 84) begin
      x = grid_pt(pick(-12, 12), frame_offx);
      y = poly_y[k];
    end else if (r < 92) begin
      x = $urandom();
      y = $urandom();
    end else begin
      x = $urandom();
      y = poly_y[k];
    end
  endtask

  task automatic run_phase(input int ph);
    int r, cnt, n_eff, n_tests, k;
    logic signed [COORD_W-1:0] ray, px, py;
    bit junk;
    no_idle = (items_sent > ITEM_GOAL * 9 / 10);
    r = pick(0, 2);
    send_gap_pct = (r == 0) ? 0 : (r == 1) ? 10 : 40;
    r = pick(0, 99);
    if (ph == 0) begin
      cnt = MAX_VERTICES;
    end else if (ph == 1) begin
      cnt = 127;
    end else if (r < 70) begin
      cnt = pick(3, 8);
    end else if (r < 82) begin
      cnt = pick(9, 24);
    end else if (r < 90) begin
      cnt = pick(0, 2);
    end else if (r < 95) begin
      cnt = MAX_VERTICES;
    end else begin
      cnt = pick(MAX_VERTICES + 1, 127);
    end
    n_eff = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
    frame_sh = (pick(0, 99) < 70) ? 16 : pick(0, 26);
    frame_offx = pick(-(1 << 26), 1 << 26);
    frame_offy = pick(-(1 << 26), 1 << 26);
    r = pick(0, 99);
    if (r < 40) begin
      ray = C_MAX;
    end else if (r < 55) begin
      ray = C_MIN;
    end else if (r < 62) begin
      ray = '0;
    end else if (r < 80) begin
      ray = grid_pt(pick(-12, 12), frame_offx);
    end else begin
      ray = $urandom();
    end
    junk = (pick(0, 3) == 0);
    settle();
    configure(cnt, ray, junk);
    build_polygon(n_eff);
    n_tests = (n_eff > 24) ? pick(3, 6) : pick(8, 24);
    if (ph == 2) long_hold_req = 1'b1;
    for (k = 0; k < n_tests; k++) begin
      if (ph == 3 && k == n_tests / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (open_tests != 0) @(negedge clk);
      end
      pick_point(px, py);
      probe_point(px, py);
    end
  endtask

  initial begin
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_WRITE;
    in_vertex_index = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_VERTEX_COUNT;
    cfg_data = '0;
    items_sent = 0;
    send_gap_pct = 20;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    frame_sh = 16;
    frame_offx = 0;
    frame_offy = 0;
    poly_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty polygon, then extreme-coordinate triangle
    probe_point('0, '0);
    put_vertex(0, C_MIN, C_MIN);
    put_vertex(1, C_MAX, C_MIN);
    put_vertex(2, '0, C_MAX);
    put_vertex(MAX_VERTICES - 1, C_MAX, C_MAX);
    settle();
    configure(2, C_MAX, 1'b0);
    probe_point('0, '0);
    settle();
    configure(3, C_MAX, 1'b0);
    probe_point('0, '0);
    probe_point(C_MIN, C_MIN);
    probe_point('0, C_MIN);
    probe_point(C_MAX, C_MAX);
    settle();
    configure(3, C_MIN, 1'b0);
    probe_point('0, '0);
    probe_point(C_MAX, '0);

    // square: boundary, collinear with an edge, plain crossings
    put_vertex(0, '0, '0);
    put_vertex(1, 4 * UNIT, '0);
    put_vertex(2, 4 * UNIT, 4 * UNIT);
    put_vertex(3, '0, 4 * UNIT);
    settle();
    configure(4, C_MAX, 1'b0);
    probe_point(2 * UNIT, 2 * UNIT);
    probe_point(2 * UNIT, '0);
    probe_point(-2 * UNIT, '0);
    probe_point(-2 * UNIT, 2 * UNIT);

    // diamond: ray through a vertex counts twice
    put_vertex(0, '0, -4 * UNIT);
    put_vertex(1, 4 * UNIT, '0);
    put_vertex(2, '0, 4 * UNIT);
    put_vertex(3, -4 * UNIT, '0);
    probe_point(-UNIT, '0);
    probe_point('0, UNIT);

    ph = 0;
    while (items_sent < ITEM_GOAL) begin
      run_phase(ph);
      ph++;
    end

    no_idle = 1'b1;
    settle();
    if (mismatch_count == 0 && open_tests == 0) begin
      $display("tb_point_in_polygon_test_core: clean");
    end else begin
      $display("tb_point_in_polygon_test_core: errors");
    end
    $finish;
  end

endmodule
